### rtl/core/gne_pkg.sv
// ----------------------------------------------------------------------------
// gne_pkg
// Shared types and constants of the gate netlist evaluator.
// ----------------------------------------------------------------------------
package gne_pkg;

    // default sizes
    localparam int MAX_GATES_DEF = 256;
    localparam int NUM_VARS_DEF  = 64;
    localparam int MAX_IO_DEF    = 16;

    // fixed field widths
    localparam int IDX_W = 6;   // variable index
    localparam int OP_W  = 3;   // gate kind
    localparam int ACT_W = 2;   // action code
    localparam int VEC_W = 16;  // input / output vector
    localparam int LEN_W = 9;   // reported program length
    localparam int CFG_W = 5;   // config data

    // config register indexes
    localparam logic CFG_NUM_INPUTS  = 1'b0;
    localparam logic CFG_NUM_OUTPUTS = 1'b1;

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_EVAL   = 2'd2
    } action_t;

    typedef enum logic [OP_W-1:0] {
        OP_NOT  = 3'd0,
        OP_AND  = 3'd1,
        OP_OR   = 3'd2,
        OP_NAND = 3'd3,
        OP_NOR  = 3'd4,
        OP_XOR  = 3'd5
    } gate_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_RUN,
        S_OUT,
        S_DONE
    } state_t;

    // one stored gate: op[20:18], a[17:12], b[11:6], d[5:0]
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] src_a;
        logic [IDX_W-1:0] src_b;
        logic [IDX_W-1:0] dst;
    } gate_instr_t;

    // write request into the variable store
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic             val;
    } var_wr_t;

endpackage

### rtl/core/gne_var_store.sv
// ----------------------------------------------------------------------------
// gne_var_store
// One-bit variable memory: one write port, two registered read ports,
// write-to-read forwarding, and a clearing pass after reset.
// ----------------------------------------------------------------------------
module gne_var_store
    import gne_pkg::*;
#(
    parameter int NUM_VARS = NUM_VARS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  var_wr_t          wr,
    input  logic [IDX_W-1:0] rd_a_idx,
    input  logic [IDX_W-1:0] rd_b_idx,
    output logic             rd_a_val,
    output logic             rd_b_val,
    output logic             ready
);

    // only indices below 2**IDX_W can ever be addressed
    localparam int DEPTH = (NUM_VARS < (2 ** IDX_W)) ? NUM_VARS : (2 ** IDX_W);
    localparam int AW    = $clog2(DEPTH);
    localparam logic [IDX_W:0] DEPTH_L = (IDX_W + 1)'(DEPTH);

    logic          mem [DEPTH];
    logic [AW-1:0] clr_ptr_reg;
    logic          clr_busy_reg;

    logic wr_ok;
    logic a_ok, b_ok;
    logic a_q_reg, b_q_reg;
    logic a_ok_reg, b_ok_reg;
    logic a_fwd_reg, b_fwd_reg;
    logic wv_reg;

    assign wr_ok = wr.en && ({1'b0, wr.idx} < DEPTH_L);
    assign a_ok  = {1'b0, rd_a_idx} < DEPTH_L;
    assign b_ok  = {1'b0, rd_b_idx} < DEPTH_L;

    // clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_ptr_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_ptr_reg <= clr_ptr_reg + 1'b1;
            if (clr_ptr_reg == AW'(DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // memory array
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_ptr_reg] <= 1'b0;
        end else if (wr_ok) begin
            mem[AW'(wr.idx)] <= wr.val;
        end
        a_q_reg <= mem[AW'(rd_a_idx)];
        b_q_reg <= mem[AW'(rd_b_idx)];
    end

    // forward a write landing in the same cycle as the read
    always_ff @(posedge aclk) begin
        a_ok_reg  <= a_ok;
        b_ok_reg  <= b_ok;
        a_fwd_reg <= wr_ok && (wr.idx == rd_a_idx);
        b_fwd_reg <= wr_ok && (wr.idx == rd_b_idx);
        wv_reg    <= wr.val;
    end

    assign rd_a_val = a_ok_reg && (a_fwd_reg ? wv_reg : a_q_reg);
    assign rd_b_val = b_ok_reg && (b_fwd_reg ? wv_reg : b_q_reg);
    assign ready    = !clr_busy_reg;

endmodule

### rtl/core/gate_netlist_evaluator.sv
// ----------------------------------------------------------------------------
// gate_netlist_evaluator
// Gate-level logic simulator: stores a program of gates, evaluates it on a
// one-bit variable store, one gate per cycle.
// ----------------------------------------------------------------------------
// Clear, append and unknown actions go from S_IDLE straight to S_DONE, which
// registers the result word. Evaluate loads NI inputs, runs G stored gates
// and reads NO outputs; the gate loop issues one program read per cycle
// through a three-stage pipeline around the variable memory ports.
// One word is in work at a time; a finished result waits in the output register.
// Reset is synchronous, active low; afterwards the variable store runs a
// clearing pass over all min(NUM_VARS, 64) entries before a word is taken.
// ----------------------------------------------------------------------------
module gate_netlist_evaluator
    import gne_pkg::*;
#(
    parameter int MAX_GATES = MAX_GATES_DEF,
    parameter int NUM_VARS  = NUM_VARS_DEF,
    parameter int MAX_IO    = MAX_IO_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    // configuration
    input  logic             cfg_we,
    input  logic             cfg_idx,
    input  logic [CFG_W-1:0] cfg_data,
    // input words
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [ACT_W-1:0] s_action,
    input  logic [OP_W-1:0]  s_gate_op,
    input  logic [IDX_W-1:0] s_src_a,
    input  logic [IDX_W-1:0] s_src_b,
    input  logic [IDX_W-1:0] s_dst,
    input  logic [VEC_W-1:0] s_input_vector,
    // result words
    output logic             m_valid,
    input  logic             m_ready,
    output logic [VEC_W-1:0] m_out_vector,
    output logic             m_status,
    output logic [LEN_W-1:0] m_program_length
);

    localparam int CNT_W  = $clog2(MAX_GATES + 1);    // gate count
    localparam int PA_W   = $clog2(MAX_GATES);        // program address
    localparam int IO_CW  = $clog2(MAX_IO + 1);       // input count
    localparam int NO_MAX = (MAX_IO < VEC_W) ? MAX_IO : VEC_W;
    localparam int NO_CW  = $clog2(NO_MAX + 1);       // output count

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic [CFG_W-1:0] num_in_reg, num_out_reg;
    logic [CNT_W-1:0] total_reg;

    gate_instr_t      prog_mem [MAX_GATES];
    gate_instr_t      prog_q_reg;

    logic [VEC_W-1:0] vec_reg;
    logic [IO_CW-1:0] ni_reg, j_reg;
    logic [NO_CW-1:0] no_reg, k_reg, o_pos_reg;
    logic             o_v_reg;
    logic [CNT_W-1:0] g_reg;
    logic             p1_v_reg, p2_v_reg;
    logic [OP_W-1:0]  p2_op_reg;
    logic [IDX_W-1:0] p2_dst_reg;

    logic [VEC_W-1:0] res_vec_reg;
    logic             res_status_reg;

    logic             m_valid_reg, m_status_reg;
    logic [VEC_W-1:0] m_vec_reg;
    logic [LEN_W-1:0] m_len_reg;

    // ------------------------------------------------------------------
    // Variable store
    // ------------------------------------------------------------------
    var_wr_t          var_wr;
    logic [IDX_W-1:0] rd_a_idx, rd_b_idx;
    logic             rd_a_val, rd_b_val;
    logic             store_ready;

    gne_var_store #(
        .NUM_VARS (NUM_VARS)
    ) u_var_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (var_wr),
        .rd_a_idx (rd_a_idx),
        .rd_b_idx (rd_b_idx),
        .rd_a_val (rd_a_val),
        .rd_b_val (rd_b_val),
        .ready    (store_ready)
    );

    // ------------------------------------------------------------------
    // Handshake and control terms
    // ------------------------------------------------------------------
    logic accept, full, issue_gate, issue_out, out_free, in_bit;
    logic gate_val, gate_en;

    assign s_ready    = (state_reg == S_IDLE) && store_ready;
    assign accept     = s_valid && s_ready;
    assign full       = (total_reg == CNT_W'(MAX_GATES));
    assign issue_gate = (state_reg == S_RUN) && (g_reg < total_reg);
    assign issue_out  = (state_reg == S_OUT) && (k_reg < no_reg);
    assign out_free   = !m_valid_reg || m_ready;
    // input variables past the vector width load zero
    assign in_bit     = (int'(j_reg) < VEC_W) ? vec_reg[4'(j_reg)] : 1'b0;

    // gate evaluation at the last pipeline stage
    always_comb begin
        gate_en  = 1'b1;
        gate_val = 1'b0;
        case (p2_op_reg)
            OP_NOT:  gate_val = !rd_a_val;
            OP_AND:  gate_val = rd_a_val & rd_b_val;
            OP_OR:   gate_val = rd_a_val | rd_b_val;
            OP_NAND: gate_val = !(rd_a_val & rd_b_val);
            OP_NOR:  gate_val = !(rd_a_val | rd_b_val);
            OP_XOR:  gate_val = rd_a_val ^ rd_b_val;
            default: gate_en  = 1'b0;   // unknown kind leaves dst alone
        endcase
    end

    // ------------------------------------------------------------------
    // FSM: next state and store access
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        var_wr     = '0;
        rd_b_idx   = prog_q_reg.src_b;
        rd_a_idx   = (state_reg == S_OUT) ? (IDX_W'(MAX_IO) + IDX_W'(k_reg))
                                          : prog_q_reg.src_a;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = (s_action == ACT_EVAL) ? S_LOAD : S_DONE;
                end
            end
            S_LOAD: begin
                if (j_reg == ni_reg) begin
                    state_next = S_RUN;
                end else begin
                    var_wr.en  = 1'b1;
                    var_wr.idx = IDX_W'(j_reg);
                    var_wr.val = in_bit;
                end
            end
            S_RUN: begin
                var_wr.en  = p2_v_reg && gate_en;
                var_wr.idx = p2_dst_reg;
                var_wr.val = gate_val;
                // wait for the pipeline to drain before reading outputs
                if ((g_reg == total_reg) && !p1_v_reg && !p2_v_reg) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if ((k_reg == no_reg) && !o_v_reg) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_in_reg  <= CFG_W'(1);
            num_out_reg <= CFG_W'(1);
        end else if (cfg_we) begin
            if (cfg_idx == CFG_NUM_INPUTS) begin
                num_in_reg <= cfg_data;
            end else begin
                num_out_reg <= cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // Program memory
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (accept && (s_action == ACT_APPEND) && !full) begin
            prog_mem[PA_W'(total_reg)] <= {s_gate_op, s_src_a, s_src_b, s_dst};
        end
        prog_q_reg <= prog_mem[PA_W'(g_reg)];
    end

    // ------------------------------------------------------------------
    // Control registers: gate count, pipeline valids, output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg   <= '0;
            p1_v_reg    <= 1'b0;
            p2_v_reg    <= 1'b0;
            o_v_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            p1_v_reg <= issue_gate;
            p2_v_reg <= p1_v_reg;
            o_v_reg  <= issue_out;
            if (accept) begin
                if (s_action == ACT_CLEAR) begin
                    total_reg <= '0;
                end else if ((s_action == ACT_APPEND) && !full) begin
                    total_reg <= total_reg + 1'b1;
                end
            end
            if ((state_reg == S_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            res_vec_reg    <= '0;
            res_status_reg <= (s_action == ACT_APPEND) && full;
            vec_reg        <= s_input_vector;
            ni_reg         <= (int'(num_in_reg) > MAX_IO) ? IO_CW'(MAX_IO)
                                                          : IO_CW'(num_in_reg);
            no_reg         <= (num_out_reg > CFG_W'(NO_MAX)) ? NO_CW'(NO_MAX)
                                                             : NO_CW'(num_out_reg);
            j_reg          <= '0;
            g_reg          <= '0;
            k_reg          <= '0;
        end
        if ((state_reg == S_LOAD) && (j_reg != ni_reg)) begin
            j_reg <= j_reg + 1'b1;
        end
        if (issue_gate) begin
            g_reg <= g_reg + 1'b1;
        end
        p2_op_reg  <= prog_q_reg.op;
        p2_dst_reg <= prog_q_reg.dst;
        if (issue_out) begin
            k_reg <= k_reg + 1'b1;
        end
        o_pos_reg <= k_reg;
        if (o_v_reg) begin
            res_vec_reg[4'(o_pos_reg)] <= rd_a_val;
        end
        if ((state_reg == S_DONE) && out_free) begin
            m_vec_reg    <= res_vec_reg;
            m_status_reg <= res_status_reg;
            m_len_reg    <= LEN_W'(total_reg);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_vector     = m_vec_reg;
    assign m_status         = m_status_reg;
    assign m_program_length = m_len_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= CNT_W'(MAX_GATES))
        else $error("gate count above program depth");

    a_full_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_action == ACT_APPEND) && full) |=> res_status_reg)
        else $error("append to full program not flagged");

    a_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) |-> (!p1_v_reg && !p2_v_reg))
        else $error("output read before gate pipeline drained");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result word raised outside completion");

    a_no_take_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !store_ready |-> !s_ready)
        else $error("word taken during variable clearing pass");

endmodule
